// ----- hw/rtl/gapf_pkg.sv -----
// ----------------------------------------------------------------------------
// gapf_pkg
// Shared constants, types and helpers of the grid A* path finder.
// ----------------------------------------------------------------------------
package gapf_pkg;

   localparam int GRID_WIDTH  = 8;
   localparam int GRID_HEIGHT = 8;
   localparam int CELL_COUNT  = GRID_WIDTH * GRID_HEIGHT;
   localparam int CELL_BITS   = 6;
   localparam int COORD_BITS  = 3;
   localparam int DIM_BITS    = 4;
   localparam int PRI_BITS    = 10;
   localparam int DIR_BITS    = 2;
   localparam int ROOT_BITS   = 4;
   localparam int RAD_BITS    = 7;
   localparam int SCAN_BITS   = CELL_BITS + 1;

   localparam logic [PRI_BITS-1:0] STEP_COST = 10'd10;
   localparam logic [DIM_BITS-1:0] MAX_COLS  = 4'd8;
   localparam logic [DIM_BITS-1:0] MAX_ROWS  = 4'd8;

   localparam logic [DIR_BITS-1:0] DIR_PX = 2'd0;
   localparam logic [DIR_BITS-1:0] DIR_PY = 2'd1;
   localparam logic [DIR_BITS-1:0] DIR_NX = 2'd2;
   localparam logic [DIR_BITS-1:0] DIR_NY = 2'd3;

   localparam logic OP_WALL   = 1'b0;
   localparam logic OP_SEARCH = 1'b1;

   localparam logic REG_WIDTH_IN_USE  = 1'b0;
   localparam logic REG_HEIGHT_IN_USE = 1'b1;

   typedef enum logic [1:0] {
      OUT_FAIL,
      OUT_TRIVIAL,
      OUT_STEP
   } out_kind_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DECIDE,
      ST_H_START,
      ST_SCAN_START,
      ST_SCAN,
      ST_SELECT,
      ST_N_ADDR,
      ST_N_WAIT,
      ST_P_START,
      ST_P_CHK,
      ST_P_NX,
      ST_E_START,
      ST_E_RD,
      ST_E_OUT
   } state_type;

   typedef struct packed {
      logic                  operation;
      logic [COORD_BITS-1:0] cell_x;
      logic [COORD_BITS-1:0] cell_y;
      logic                  is_wall;
      logic [COORD_BITS-1:0] start_x;
      logic [COORD_BITS-1:0] start_y;
      logic [COORD_BITS-1:0] goal_x;
      logic [COORD_BITS-1:0] goal_y;
   } req_payload_type;

   typedef struct packed {
      logic         load;
      logic         wall_wr;
      logic         init;
      logic         h_start;
      logic         h_src_nbr;
      logic         seed;
      logic         scan_start;
      logic         scan;
      logic         select;
      logic         nbr_first;
      logic         nbr_next;
      logic         nbr_upd;
      logic         path_start;
      logic         path_rd;
      logic         path_nx;
      logic         emit_start;
      logic         emit_nx;
      logic         out_load;
      out_kind_type out_kind;
   } dp_cmd_type;

   typedef struct packed {
      logic is_write;
      logic bad_range;
      logic same_cell;
      logic h_done;
      logic scan_done;
      logic any_open;
      logic cur_is_goal;
      logic nbr_ok;
      logic d_last;
      logic p_is_start;
      logic k_zero;
      logic out_free;
   } dp_status_type;

   function automatic logic [DIM_BITS-1:0] clamp_dim(input logic [DIM_BITS-1:0] v,
                                                     input logic [DIM_BITS-1:0] lim);
      logic [DIM_BITS-1:0] r;
      r = v;
      if (r == '0) begin
         r = 4'd1;
      end
      if (r > lim) begin
         r = lim;
      end
      return r;
   endfunction

endpackage

// ----- hw/rtl/gapf_req_if.sv -----
// ----------------------------------------------------------------------------
// gapf_req_if
// Request channel: wall writes and search requests.
// ----------------------------------------------------------------------------
interface gapf_req_if;
   logic                             valid;
   logic                             ready;
   logic                             operation;
   logic [gapf_pkg::COORD_BITS-1:0]  cell_x;
   logic [gapf_pkg::COORD_BITS-1:0]  cell_y;
   logic                             is_wall;
   logic [gapf_pkg::COORD_BITS-1:0]  start_x;
   logic [gapf_pkg::COORD_BITS-1:0]  start_y;
   logic [gapf_pkg::COORD_BITS-1:0]  goal_x;
   logic [gapf_pkg::COORD_BITS-1:0]  goal_y;

   modport source (output valid, operation, cell_x, cell_y, is_wall,
                   start_x, start_y, goal_x, goal_y, input ready);
   modport sink   (input valid, operation, cell_x, cell_y, is_wall,
                   start_x, start_y, goal_x, goal_y, output ready);
endinterface

// ----- hw/rtl/gapf_rsp_if.sv -----
// ----------------------------------------------------------------------------
// gapf_rsp_if
// Result channel: path cells and search status.
// ----------------------------------------------------------------------------
interface gapf_rsp_if;
   logic                             valid;
   logic                             ready;
   logic [gapf_pkg::COORD_BITS-1:0]  step_x;
   logic [gapf_pkg::COORD_BITS-1:0]  step_y;
   logic                             has_step;
   logic                             found;
   logic                             last;

   modport source (output valid, step_x, step_y, has_step, found, last, input ready);
   modport sink   (input valid, step_x, step_y, has_step, found, last, output ready);
endinterface

// ----- hw/rtl/gapf_ram.sv -----
// ----------------------------------------------------------------------------
// gapf_ram
// Generic memory, one write port and one read port with registered read.
// ----------------------------------------------------------------------------
module gapf_ram #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hw/rtl/gapf_ctrl.sv -----
// ----------------------------------------------------------------------------
// gapf_ctrl
// Sequencer of wall writes and of the search: scan, expansion, back trace and path output.
// ----------------------------------------------------------------------------
module gapf_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  gapf_pkg::dp_status_type status,
   output gapf_pkg::dp_cmd_type    cmd
);

   gapf_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= gapf_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      cmd.out_kind = gapf_pkg::OUT_FAIL;
      req_ready    = 1'b0;
      unique case (state_ff)
         gapf_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = gapf_pkg::ST_DECIDE;
            end
         end
         gapf_pkg::ST_DECIDE: begin
            priority if (status.is_write) begin
               cmd.wall_wr = 1'b1;
               state_in    = gapf_pkg::ST_IDLE;
            end else if (status.bad_range || status.same_cell) begin
               if (status.out_free) begin
                  cmd.out_load = 1'b1;
                  cmd.out_kind = status.bad_range ? gapf_pkg::OUT_FAIL
                                                  : gapf_pkg::OUT_TRIVIAL;
                  state_in     = gapf_pkg::ST_IDLE;
               end
            end else begin
               cmd.init    = 1'b1;
               cmd.h_start = 1'b1;
               state_in    = gapf_pkg::ST_H_START;
            end
         end
         gapf_pkg::ST_H_START: begin
            if (status.h_done) begin
               cmd.seed = 1'b1;
               state_in = gapf_pkg::ST_SCAN_START;
            end
         end
         gapf_pkg::ST_SCAN_START: begin
            cmd.scan_start = 1'b1;
            state_in       = gapf_pkg::ST_SCAN;
         end
         gapf_pkg::ST_SCAN: begin
            cmd.scan = 1'b1;
            if (status.scan_done) begin
               state_in = gapf_pkg::ST_SELECT;
            end
         end
         gapf_pkg::ST_SELECT: begin
            if (!status.any_open) begin
               if (status.out_free) begin
                  cmd.out_load = 1'b1;
                  cmd.out_kind = gapf_pkg::OUT_FAIL;
                  state_in     = gapf_pkg::ST_IDLE;
               end
            end else begin
               cmd.select = 1'b1;
               if (status.cur_is_goal) begin
                  state_in = gapf_pkg::ST_P_START;
               end else begin
                  cmd.nbr_first = 1'b1;
                  state_in      = gapf_pkg::ST_N_ADDR;
               end
            end
         end
         gapf_pkg::ST_N_ADDR: begin
            priority if (status.nbr_ok) begin
               cmd.h_start   = 1'b1;
               cmd.h_src_nbr = 1'b1;
               state_in      = gapf_pkg::ST_N_WAIT;
            end else if (status.d_last) begin
               state_in = gapf_pkg::ST_SCAN_START;
            end else begin
               cmd.nbr_next = 1'b1;
            end
         end
         gapf_pkg::ST_N_WAIT: begin
            if (status.h_done) begin
               cmd.nbr_upd = 1'b1;
               if (status.d_last) begin
                  state_in = gapf_pkg::ST_SCAN_START;
               end else begin
                  cmd.nbr_next = 1'b1;
                  state_in     = gapf_pkg::ST_N_ADDR;
               end
            end
         end
         gapf_pkg::ST_P_START: begin
            cmd.path_start = 1'b1;
            state_in       = gapf_pkg::ST_P_CHK;
         end
         gapf_pkg::ST_P_CHK: begin
            if (status.p_is_start) begin
               state_in = gapf_pkg::ST_E_START;
            end else begin
               cmd.path_rd = 1'b1;
               state_in    = gapf_pkg::ST_P_NX;
            end
         end
         gapf_pkg::ST_P_NX: begin
            cmd.path_nx = 1'b1;
            state_in    = gapf_pkg::ST_P_CHK;
         end
         gapf_pkg::ST_E_START: begin
            cmd.emit_start = 1'b1;
            state_in       = gapf_pkg::ST_E_RD;
         end
         gapf_pkg::ST_E_RD: begin
            state_in = gapf_pkg::ST_E_OUT;
         end
         gapf_pkg::ST_E_OUT: begin
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               cmd.out_kind = gapf_pkg::OUT_STEP;
               if (status.k_zero) begin
                  state_in = gapf_pkg::ST_IDLE;
               end else begin
                  cmd.emit_nx = 1'b1;
                  state_in    = gapf_pkg::ST_E_RD;
               end
            end
         end
         default: begin
            state_in = gapf_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

// ----- hw/rtl/gapf_dp.sv -----
// ----------------------------------------------------------------------------
// gapf_dp
// Datapath: grid stores, open set scan, square root unit, back trace and
// result register.
// ----------------------------------------------------------------------------
module gapf_dp (
   input  logic                                clock,
   input  logic                                reset,
   input  gapf_pkg::dp_cmd_type                cmd,
   output gapf_pkg::dp_status_type             status,
   input  gapf_pkg::req_payload_type           req_payload,
   input  logic [gapf_pkg::DIM_BITS-1:0]       width_in_use,
   input  logic [gapf_pkg::DIM_BITS-1:0]       height_in_use,
   input  logic                                rsp_ready,
   output logic                                rsp_valid,
   output logic [gapf_pkg::COORD_BITS-1:0]     rsp_step_x,
   output logic [gapf_pkg::COORD_BITS-1:0]     rsp_step_y,
   output logic                                rsp_has_step,
   output logic                                rsp_found,
   output logic                                rsp_last
);

   localparam int CB = gapf_pkg::COORD_BITS;
   localparam int IB = gapf_pkg::CELL_BITS;
   localparam int PB = gapf_pkg::PRI_BITS;
   localparam int DB = gapf_pkg::DIM_BITS;
   localparam int N  = gapf_pkg::CELL_COUNT;

   gapf_pkg::req_payload_type pl_ff;

   logic [N-1:0] open_vld_ff, closed_ff, wall_vld_ff;

   logic [gapf_pkg::RAD_BITS-1:0]  h_v_ff;
   logic [gapf_pkg::ROOT_BITS-1:0] h_r_ff;

   logic [gapf_pkg::SCAN_BITS-1:0] scan_cnt_ff;
   logic                           rd_vld_ff;
   logic [IB-1:0]                  rd_idx_ff;
   logic                           any_open_ff;
   logic [PB-1:0]                  best_ff;
   logic [IB-1:0]                  cur_ff;
   logic [gapf_pkg::DIR_BITS-1:0]  dir_ff;
   logic [IB-1:0]                  p_ff, len_ff, k_ff;

   logic          rsp_valid_ff, rsp_has_ff, rsp_found_ff, rsp_last_ff;
   logic [CB-1:0] rsp_x_ff, rsp_y_ff;

   logic [DB-1:0] w_eff, h_eff;
   logic [IB-1:0] s_idx, g_idx, n_idx, wall_idx;
   logic [CB-1:0] cx, cy, nx, ny, hx, hy, hdx, hdy, px, py;
   logic          nbr_ok;
   logic [gapf_pkg::RAD_BITS-1:0]   h_v_new;
   logic [gapf_pkg::ROOT_BITS:0]    h_next;
   logic [7:0]                      h_sq;
   logic                            h_step;
   logic [PB-1:0]                   h_val, ng, np;

   logic          wall_q;
   logic [PB-1:0] pri_q, cost_q;
   logic [gapf_pkg::DIR_BITS-1:0] back_q;
   logic [IB-1:0] buf_q;
   logic [IB-1:0] pri_rd_addr, pri_wr_addr;
   logic [PB-1:0] pri_wr_data;
   logic          pri_wr_en, cost_wr_en, upd_take;
   logic          wall_eff;

   assign w_eff = gapf_pkg::clamp_dim(width_in_use,  gapf_pkg::MAX_COLS);
   assign h_eff = gapf_pkg::clamp_dim(height_in_use, gapf_pkg::MAX_ROWS);
   assign s_idx    = {pl_ff.start_y, pl_ff.start_x};
   assign g_idx    = {pl_ff.goal_y, pl_ff.goal_x};
   assign wall_idx = {pl_ff.cell_y, pl_ff.cell_x};
   assign cx = cur_ff[CB-1:0];
   assign cy = cur_ff[IB-1:CB];

   // neighbor of the current cell in the direction under test
   always_comb begin
      nx     = cx;
      ny     = cy;
      nbr_ok = 1'b0;
      unique case (dir_ff)
         gapf_pkg::DIR_PX: begin
            nx     = cx + 3'd1;
            nbr_ok = ({1'b0, cx} + 4'd1) < w_eff;
         end
         gapf_pkg::DIR_PY: begin
            ny     = cy + 3'd1;
            nbr_ok = ({1'b0, cy} + 4'd1) < h_eff;
         end
         gapf_pkg::DIR_NX: begin
            nx     = cx - 3'd1;
            nbr_ok = cx != '0;
         end
         gapf_pkg::DIR_NY: begin
            ny     = cy - 3'd1;
            nbr_ok = cy != '0;
         end
         default: begin
            nbr_ok = 1'b0;
         end
      endcase
   end
   assign n_idx = {ny, nx};

   // predecessor along the stored back direction
   always_comb begin
      px = p_ff[CB-1:0];
      py = p_ff[IB-1:CB];
      unique case (back_q)
         gapf_pkg::DIR_PX: px = p_ff[CB-1:0] - 3'd1;
         gapf_pkg::DIR_PY: py = p_ff[IB-1:CB] - 3'd1;
         gapf_pkg::DIR_NX: px = p_ff[CB-1:0] + 3'd1;
         gapf_pkg::DIR_NY: py = p_ff[IB-1:CB] + 3'd1;
         default: px = p_ff[CB-1:0];
      endcase
   end

   // integer square root, one candidate per cycle
   assign hx  = cmd.h_src_nbr ? nx : pl_ff.start_x;
   assign hy  = cmd.h_src_nbr ? ny : pl_ff.start_y;
   assign hdx = (hx > pl_ff.goal_x) ? hx - pl_ff.goal_x : pl_ff.goal_x - hx;
   assign hdy = (hy > pl_ff.goal_y) ? hy - pl_ff.goal_y : pl_ff.goal_y - hy;
   assign h_v_new = ({4'b0, hdx} * {4'b0, hdx}) + ({4'b0, hdy} * {4'b0, hdy});
   assign h_next  = {1'b0, h_r_ff} + 5'd1;
   assign h_sq    = {3'b0, h_next} * {3'b0, h_next};
   assign h_step  = h_sq <= {1'b0, h_v_ff};
   assign h_val   = PB'(h_r_ff) * gapf_pkg::STEP_COST;

   always_ff @(posedge clock) begin
      if (cmd.h_start) begin
         h_v_ff <= h_v_new;
         h_r_ff <= '0;
      end else if (h_step) begin
         h_r_ff <= h_next[gapf_pkg::ROOT_BITS-1:0];
      end
   end

   assign wall_eff = wall_vld_ff[n_idx] & wall_q;
   assign ng       = cost_q + gapf_pkg::STEP_COST;
   assign np       = ng + h_val;
   assign upd_take = cmd.nbr_upd && !wall_eff && !closed_ff[n_idx] &&
                     (!open_vld_ff[n_idx] || pri_q > np);

   assign pri_rd_addr = cmd.scan ? scan_cnt_ff[IB-1:0] : n_idx;
   assign pri_wr_en   = cmd.seed || upd_take;
   assign pri_wr_addr = cmd.seed ? s_idx : n_idx;
   assign pri_wr_data = cmd.seed ? h_val : np;
   assign cost_wr_en  = cmd.seed || upd_take;

   gapf_ram #(.WIDTH(1), .DEPTH(N)) u_wall_ram (
      .clock(clock), .wr_en(cmd.wall_wr), .wr_addr(wall_idx),
      .wr_data(pl_ff.is_wall), .rd_addr(n_idx), .rd_data(wall_q)
   );

   gapf_ram #(.WIDTH(PB), .DEPTH(N)) u_pri_ram (
      .clock(clock), .wr_en(pri_wr_en), .wr_addr(pri_wr_addr),
      .wr_data(pri_wr_data), .rd_addr(pri_rd_addr), .rd_data(pri_q)
   );

   gapf_ram #(.WIDTH(PB), .DEPTH(N)) u_cost_ram (
      .clock(clock), .wr_en(cost_wr_en), .wr_addr(pri_wr_addr),
      .wr_data(cmd.seed ? '0 : ng), .rd_addr(cur_ff), .rd_data(cost_q)
   );

   gapf_ram #(.WIDTH(gapf_pkg::DIR_BITS), .DEPTH(N)) u_back_ram (
      .clock(clock), .wr_en(upd_take), .wr_addr(n_idx),
      .wr_data(dir_ff), .rd_addr(p_ff), .rd_data(back_q)
   );

   gapf_ram #(.WIDTH(IB), .DEPTH(N)) u_path_ram (
      .clock(clock), .wr_en(cmd.path_rd), .wr_addr(len_ff),
      .wr_data(p_ff), .rd_addr(k_ff), .rd_data(buf_q)
   );

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         pl_ff <= req_payload;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wall_vld_ff <= '0;
      end else if (cmd.wall_wr) begin
         wall_vld_ff[wall_idx] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || cmd.init) begin
         open_vld_ff <= '0;
         closed_ff   <= '0;
      end else begin
         if (cmd.seed) begin
            open_vld_ff[s_idx] <= 1'b1;
         end
         if (upd_take) begin
            open_vld_ff[n_idx] <= 1'b1;
         end
         if (cmd.select) begin
            open_vld_ff[cur_ff] <= 1'b0;
            closed_ff[cur_ff]   <= 1'b1;
         end
      end
   end

   // minimum search over the open set, lowest index wins a tie
   always_ff @(posedge clock) begin
      if (reset) begin
         scan_cnt_ff <= '0;
         rd_vld_ff   <= 1'b0;
         any_open_ff <= 1'b0;
      end else if (cmd.scan_start) begin
         scan_cnt_ff <= '0;
         rd_vld_ff   <= 1'b0;
         any_open_ff <= 1'b0;
      end else if (cmd.scan) begin
         if (scan_cnt_ff < gapf_pkg::SCAN_BITS'(N)) begin
            scan_cnt_ff <= scan_cnt_ff + 1'b1;
            rd_vld_ff   <= 1'b1;
         end else begin
            rd_vld_ff <= 1'b0;
         end
         if (rd_vld_ff && open_vld_ff[rd_idx_ff] && (!any_open_ff || pri_q < best_ff)) begin
            any_open_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rd_idx_ff <= scan_cnt_ff[IB-1:0];
      if (cmd.scan && rd_vld_ff && open_vld_ff[rd_idx_ff] &&
          (!any_open_ff || pri_q < best_ff)) begin
         best_ff <= pri_q;
         cur_ff  <= rd_idx_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.nbr_first) begin
         dir_ff <= gapf_pkg::DIR_PX;
      end else if (cmd.nbr_next) begin
         dir_ff <= dir_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.path_start) begin
         p_ff   <= g_idx;
         len_ff <= '0;
      end else begin
         if (cmd.path_rd) begin
            len_ff <= len_ff + 1'b1;
         end
         if (cmd.path_nx) begin
            p_ff <= {py, px};
         end
      end
      if (cmd.emit_start) begin
         k_ff <= len_ff - 1'b1;
      end else if (cmd.emit_nx) begin
         k_ff <= k_ff - 1'b1;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         unique case (cmd.out_kind)
            gapf_pkg::OUT_STEP: begin
               rsp_x_ff     <= buf_q[CB-1:0];
               rsp_y_ff     <= buf_q[IB-1:CB];
               rsp_has_ff   <= 1'b1;
               rsp_found_ff <= 1'b1;
               rsp_last_ff  <= k_ff == '0;
            end
            gapf_pkg::OUT_TRIVIAL: begin
               rsp_x_ff     <= '0;
               rsp_y_ff     <= '0;
               rsp_has_ff   <= 1'b0;
               rsp_found_ff <= 1'b1;
               rsp_last_ff  <= 1'b1;
            end
            default: begin
               rsp_x_ff     <= '0;
               rsp_y_ff     <= '0;
               rsp_has_ff   <= 1'b0;
               rsp_found_ff <= 1'b0;
               rsp_last_ff  <= 1'b1;
            end
         endcase
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_step_x   = rsp_x_ff;
   assign rsp_step_y   = rsp_y_ff;
   assign rsp_has_step = rsp_has_ff;
   assign rsp_found    = rsp_found_ff;
   assign rsp_last     = rsp_last_ff;

   assign status.is_write    = pl_ff.operation == gapf_pkg::OP_WALL;
   assign status.bad_range   = ({1'b0, pl_ff.start_x} >= w_eff) ||
                               ({1'b0, pl_ff.start_y} >= h_eff) ||
                               ({1'b0, pl_ff.goal_x} >= w_eff) ||
                               ({1'b0, pl_ff.goal_y} >= h_eff);
   assign status.same_cell   = s_idx == g_idx;
   assign status.h_done      = !h_step;
   assign status.scan_done   = (scan_cnt_ff == gapf_pkg::SCAN_BITS'(N)) && !rd_vld_ff;
   assign status.any_open    = any_open_ff;
   assign status.cur_is_goal = cur_ff == g_idx;
   assign status.nbr_ok      = nbr_ok;
   assign status.d_last      = dir_ff == gapf_pkg::DIR_NY;
   assign status.p_is_start  = p_ff == s_idx;
   assign status.k_zero      = k_ff == '0;
   assign status.out_free    = !rsp_valid_ff || rsp_ready;

endmodule

// ----- hw/rtl/grid_astar_path_finder.sv -----
// ----------------------------------------------------------------------------
// grid_astar_path_finder
// Four-connected A* search on an 8 by 8 wall map, path cells out in order.
//
//   channel  | dir | handshake        | payload
//   req_chan | in  | valid / ready    | operation, cell, is_wall, start, goal
//   rsp_chan | out | valid / ready    | step_x, step_y, has_step, found, last
//   csr_*    | in  | apb psel/penable | width_in_use, height_in_use
//
// wall write: taken in idle, written in decide. search: each expansion is a scan
// of the open set with select plus up to four neighbor checks (square root
// unit), then the path is traced back from the goal and each path cell is
// emitted as one result. one request in flight at a time.
// synchronous reset clears the wall map valid bits and all control state;
// no clearing pass. a stalled result holds the engine, which takes requests only while idle.
// ----------------------------------------------------------------------------
module grid_astar_path_finder (
   input  logic        clock,
   input  logic        reset,
   gapf_req_if.sink    req_chan,
   gapf_rsp_if.source  rsp_chan,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   gapf_pkg::dp_cmd_type      cmd;
   gapf_pkg::dp_status_type   status;
   gapf_pkg::req_payload_type req_payload;

   logic [gapf_pkg::DIM_BITS-1:0] width_ff, height_ff;
   logic                          csr_wr;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= gapf_pkg::MAX_COLS;
         height_ff <= gapf_pkg::MAX_ROWS;
      end else if (csr_wr) begin
         if (csr_paddr[2] == gapf_pkg::REG_WIDTH_IN_USE) begin
            width_ff <= csr_pwdata[gapf_pkg::DIM_BITS-1:0];
         end else begin
            height_ff <= csr_pwdata[gapf_pkg::DIM_BITS-1:0];
         end
      end
   end

   assign csr_prdata = (csr_paddr[2] == gapf_pkg::REG_HEIGHT_IN_USE) ?
                       32'(height_ff) : 32'(width_ff);

   assign req_payload.operation = req_chan.operation;
   assign req_payload.cell_x    = req_chan.cell_x;
   assign req_payload.cell_y    = req_chan.cell_y;
   assign req_payload.is_wall   = req_chan.is_wall;
   assign req_payload.start_x   = req_chan.start_x;
   assign req_payload.start_y   = req_chan.start_y;
   assign req_payload.goal_x    = req_chan.goal_x;
   assign req_payload.goal_y    = req_chan.goal_y;

   gapf_ctrl u_ctrl (
      .clock(clock), .reset(reset),
      .req_valid(req_chan.valid), .req_ready(req_chan.ready),
      .status(status), .cmd(cmd)
   );

   gapf_dp u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .status(status),
      .req_payload(req_payload),
      .width_in_use(width_ff), .height_in_use(height_ff),
      .rsp_ready(rsp_chan.ready), .rsp_valid(rsp_chan.valid),
      .rsp_step_x(rsp_chan.step_x), .rsp_step_y(rsp_chan.step_y),
      .rsp_has_step(rsp_chan.has_step), .rsp_found(rsp_chan.found),
      .rsp_last(rsp_chan.last)
   );

endmodule

// ----- hw/rtl/gapf_checker.sv -----
// ----------------------------------------------------------------------------
// gapf_checker
// Port level checks of the path finder result channel.
// ----------------------------------------------------------------------------
module gapf_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic rsp_has_step,
   input logic rsp_found,
   input logic rsp_last
);

   // a stalled result stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result dropped while stalled");

   // a path cell only comes with a found search
   a_step_found: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_has_step |-> rsp_found)
      else $error("path cell without found");

   // a failed search gives one closing result with no cell
   a_fail_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_found |-> rsp_last && !rsp_has_step)
      else $error("failed search result malformed");

   // a request taken means the engine was free, so no new one next cycle
   a_req_gap: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken on back to back cycles");

endmodule

bind grid_astar_path_finder gapf_checker u_gapf_checker (
   .clock(clock),
   .reset(reset),
   .req_valid(req_chan.valid),
   .req_ready(req_chan.ready),
   .rsp_valid(rsp_chan.valid),
   .rsp_ready(rsp_chan.ready),
   .rsp_has_step(rsp_chan.has_step),
   .rsp_found(rsp_chan.found),
   .rsp_last(rsp_chan.last)
);

// ----- test/grid_astar_path_finder_tb.sv -----
// ----------------------------------------------------------------------------
// grid_astar_path_finder_tb
// Self-checking bench for the grid A* path finder: wall writes and searches
// are driven with random gaps, each search is predicted by an internal A*
// model and every path result is compared field by field in order.
// ----------------------------------------------------------------------------
module grid_astar_path_finder_tb;

   typedef struct packed {
      logic [gapf_pkg::COORD_BITS-1:0] step_x;
      logic [gapf_pkg::COORD_BITS-1:0] step_y;
      logic                            has_step;
      logic                            found;
      logic                            last;
   } path_step_type;

   logic        clock;
   logic        reset;
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [2:0]  csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   gapf_req_if req_chan ();
   gapf_rsp_if rsp_chan ();

   grid_astar_path_finder i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan.sink),
      .rsp_chan    (rsp_chan.source),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // predictor state
   logic                          walls [gapf_pkg::CELL_COUNT];
   logic [gapf_pkg::DIM_BITS-1:0] cols_reg;
   logic [gapf_pkg::DIM_BITS-1:0] rows_reg;
   path_step_type                 expected_steps [$];

   int  error_count;
   int  search_count;
   int  step_count;
   int  not_found_count;
   int  accepted_count;
   bit  idle_enable;

   always begin
      clock = 1'b0;
      #4;
      clock = 1'b1;
      #4;
   end

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
      error_count++;
   endtask

   function automatic void queue_step(input path_step_type s);
      expected_steps.insert(expected_steps.size(), s);
   endfunction

   function automatic int root_floor(input int v);
      int r;
      r = 0;
      while ((r + 1) * (r + 1) <= v) begin
         r++;
      end
      return r;
   endfunction

   function automatic int dist_cost(input int x, input int y, input int gx, input int gy);
      int dx;
      int dy;
      dx = (x > gx) ? x - gx : gx - x;
      dy = (y > gy) ? y - gy : gy - y;
      return 10 * root_floor(dx * dx + dy * dy);
   endfunction

   function automatic int used_dim(input logic [gapf_pkg::DIM_BITS-1:0] v);
      if (v == 0) begin
         return 1;
      end
      return (v > 8) ? 8 : int'(v);
   endfunction

   function automatic path_step_type make_step(input int x, input int y, input bit has,
                                               input bit fnd, input bit lst);
      path_step_type s;
      s.step_x   = x[gapf_pkg::COORD_BITS-1:0];
      s.step_y   = y[gapf_pkg::COORD_BITS-1:0];
      s.has_step = has;
      s.found    = fnd;
      s.last     = lst;
      return s;
   endfunction

   // runs the search and queues the path results it produces
   function automatic void predict_search(input int sx, input int sy, input int gx,
                                          input int gy);
      int w;
      int h;
      int s;
      int g;
      int cur;
      int best;
      int nx;
      int ny;
      int n;
      int ng;
      int np;
      int p;
      int len;
      int prio [gapf_pkg::CELL_COUNT];
      int cost [gapf_pkg::CELL_COUNT];
      int back [gapf_pkg::CELL_COUNT];
      bit closed [gapf_pkg::CELL_COUNT];
      int trail [gapf_pkg::CELL_COUNT];
      int ddx [4];
      int ddy [4];
      ddx = '{1, 0, -1, 0};
      ddy = '{0, 1, 0, -1};
      w = used_dim(cols_reg);
      h = used_dim(rows_reg);
      search_count++;
      if (sx >= w || sy >= h || gx >= w || gy >= h) begin
         queue_step(make_step(0, 0, 0, 0, 1));
         not_found_count++;
         return;
      end
      s = sy * gapf_pkg::GRID_WIDTH + sx;
      g = gy * gapf_pkg::GRID_WIDTH + gx;
      if (s == g) begin
         queue_step(make_step(0, 0, 0, 1, 1));
         return;
      end
      for (int i = 0; i < gapf_pkg::CELL_COUNT; i++) begin
         prio[i] = 0;
         closed[i] = 0;
         cost[i] = 0;
         back[i] = 0;
      end
      prio[s] = dist_cost(sx, sy, gx, gy);
      forever begin
         cur = -1;
         best = 0;
         for (int i = 0; i < gapf_pkg::CELL_COUNT; i++) begin
            if (prio[i] != 0 && (cur < 0 || prio[i] < best)) begin
               cur = i;
               best = prio[i];
            end
         end
         if (cur < 0) begin
            queue_step(make_step(0, 0, 0, 0, 1));
            not_found_count++;
            return;
         end
         prio[cur] = 0;
         closed[cur] = 1;
         if (cur == g) begin
            break;
         end
         for (int d = 0; d < 4; d++) begin
            nx = cur % gapf_pkg::GRID_WIDTH + ddx[d];
            ny = cur / gapf_pkg::GRID_WIDTH + ddy[d];
            if (nx < 0 || ny < 0 || nx >= w || ny >= h) begin
               continue;
            end
            n = ny * gapf_pkg::GRID_WIDTH + nx;
            if (walls[n] || closed[n]) begin
               continue;
            end
            ng = cost[cur] + 10;
            np = ng + dist_cost(nx, ny, gx, gy);
            if (prio[n] == 0 || prio[n] > np) begin
               prio[n] = np;
               cost[n] = ng;
               back[n] = d;
            end
         end
      end
      len = 0;
      p = g;
      while (p != s && len < gapf_pkg::CELL_COUNT) begin
         trail[len] = p;
         len++;
         nx = p % gapf_pkg::GRID_WIDTH - ddx[back[p]];
         ny = p / gapf_pkg::GRID_WIDTH - ddy[back[p]];
         if (nx < 0 || ny < 0 || nx >= gapf_pkg::GRID_WIDTH ||
             ny >= gapf_pkg::GRID_HEIGHT) begin
            break;
         end
         p = ny * gapf_pkg::GRID_WIDTH + nx;
      end
      if (len > 63) begin
         len = 63;
      end
      for (int k = 0; k < len; k++) begin
         p = trail[len - 1 - k];
         queue_step(make_step(p % gapf_pkg::GRID_WIDTH, p / gapf_pkg::GRID_WIDTH, 1, 1,
                              k == len - 1));
      end
   endfunction

   task automatic send_request(input logic op, input int ax, input int ay, input logic wall,
                               input int bx, input int by, input int cx, input int cy);
      int gap;
      if (idle_enable && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 9);
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid     <= 1'b1;
      req_chan.operation <= op;
      req_chan.cell_x    <= ax[gapf_pkg::COORD_BITS-1:0];
      req_chan.cell_y    <= ay[gapf_pkg::COORD_BITS-1:0];
      req_chan.is_wall   <= wall;
      req_chan.start_x   <= bx[gapf_pkg::COORD_BITS-1:0];
      req_chan.start_y   <= by[gapf_pkg::COORD_BITS-1:0];
      req_chan.goal_x    <= cx[gapf_pkg::COORD_BITS-1:0];
      req_chan.goal_y    <= cy[gapf_pkg::COORD_BITS-1:0];
      @(posedge clock);
      while (!req_chan.ready) begin
         @(posedge clock);
      end
      if (op == gapf_pkg::OP_WALL) begin
         walls[ay * gapf_pkg::GRID_WIDTH + ax] = wall;
      end else begin
         predict_search(bx, by, cx, cy);
      end
      accepted_count++;
   endtask

   task automatic write_wall(input int x, input int y, input logic wall);
      send_request(gapf_pkg::OP_WALL, x, y, wall, $urandom_range(0, 7),
                   $urandom_range(0, 7), $urandom_range(0, 7), $urandom_range(0, 7));
   endtask

   task automatic run_search(input int sx, input int sy, input int gx, input int gy);
      send_request(gapf_pkg::OP_SEARCH, $urandom_range(0, 7), $urandom_range(0, 7),
                   1'($urandom_range(0, 1)), sx, sy, gx, gy);
   endtask

   task automatic wait_drained();
      req_chan.valid <= 1'b0;
      while (expected_steps.size() != 0) begin
         @(posedge clock);
      end
      // a trailing wall write may still be in progress
      repeat (20) @(posedge clock);
   endtask

   task automatic write_csr(input logic reg_index, input int value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {reg_index, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) begin
         @(posedge clock);
      end
      if (reg_index == gapf_pkg::REG_WIDTH_IN_USE) begin
         cols_reg = value[gapf_pkg::DIM_BITS-1:0];
      end else begin
         rows_reg = value[gapf_pkg::DIM_BITS-1:0];
      end
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_area(input int cols, input int rows);
      wait_drained();
      write_csr(gapf_pkg::REG_WIDTH_IN_USE, cols);
      write_csr(gapf_pkg::REG_HEIGHT_IN_USE, rows);
   endtask

   task automatic clear_walls();
      for (int i = 0; i < gapf_pkg::CELL_COUNT; i++) begin
         if (walls[i]) begin
            write_wall(i % gapf_pkg::GRID_WIDTH, i / gapf_pkg::GRID_WIDTH, 1'b0);
         end
      end
   endtask

   task automatic test_directed();
      run_search(0, 0, 7, 7);
      run_search(7, 7, 0, 0);
      run_search(3, 3, 3, 3);
      // wall across row 2 with a gap at column 7
      for (int x = 0; x < 7; x++) begin
         write_wall(x, 2, 1'b1);
      end
      run_search(0, 0, 0, 4);
      write_wall(7, 2, 1'b1);
      run_search(0, 0, 0, 4);
      run_search(0, 2, 5, 5);
      run_search(1, 1, 4, 2);
      clear_walls();
      run_search(0, 7, 7, 0);
   endtask

   task automatic test_area_limits();
      set_area(0, 0);
      run_search(0, 0, 0, 0);
      run_search(0, 0, 1, 0);
      set_area(15, 15);
      run_search(0, 0, 7, 7);
      set_area(3, 5);
      run_search(0, 0, 2, 4);
      run_search(0, 0, 3, 0);
      run_search(2, 4, 0, 5);
      set_area(8, 1);
      run_search(0, 0, 7, 0);
      set_area(8, 8);
   endtask

   task automatic test_random_maze(input int count);
      int sx;
      int sy;
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(0, 2) == 0) begin
            write_wall($urandom_range(0, 7), $urandom_range(0, 7),
                       1'($urandom_range(0, 3) == 0));
         end else begin
            sx = $urandom_range(0, 7);
            sy = $urandom_range(0, 7);
            // mostly keep the start open so the search gets going
            if (walls[sy * gapf_pkg::GRID_WIDTH + sx] && $urandom_range(0, 3) != 0) begin
               write_wall(sx, sy, 1'b0);
            end
            run_search(sx, sy, $urandom_range(0, 7), $urandom_range(0, 7));
         end
         if (i == count / 2) begin
            wait_drained();
         end
      end
   endtask

   task automatic test_random_areas();
      set_area($urandom_range(2, 6), $urandom_range(2, 6));
      test_random_maze(25);
      set_area($urandom_range(0, 15), $urandom_range(0, 15));
      test_random_maze(15);
      set_area(8, 8);
   endtask

   // result checker with random back-pressure
   initial begin
      int stall;
      path_step_type want;
      rsp_chan.ready <= 1'b0;
      @(negedge reset);
      forever begin
         if (idle_enable && $urandom_range(0, 3) == 0) begin
            rsp_chan.ready <= 1'b0;
            stall = $urandom_range(1, 9);
            repeat (stall) @(posedge clock);
         end
         rsp_chan.ready <= 1'b1;
         @(posedge clock);
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (expected_steps.size() == 0) begin
               report_mismatch("unexpected result", 1, 0);
            end else begin
               want = expected_steps.pop_front();
               if (want.has_step) begin
                  step_count++;
               end
               if (rsp_chan.step_x !== want.step_x) begin
                  report_mismatch("step_x", rsp_chan.step_x, want.step_x);
               end
               if (rsp_chan.step_y !== want.step_y) begin
                  report_mismatch("step_y", rsp_chan.step_y, want.step_y);
               end
               if (rsp_chan.has_step !== want.has_step) begin
                  report_mismatch("has_step", rsp_chan.has_step, want.has_step);
               end
               if (rsp_chan.found !== want.found) begin
                  report_mismatch("found", rsp_chan.found, want.found);
               end
               if (rsp_chan.last !== want.last) begin
                  report_mismatch("last", rsp_chan.last, want.last);
               end
            end
         end
      end
   end

   initial begin
      #40000000;
      $display("timeout with %0d results outstanding", expected_steps.size());
      $display("*** FAILED ***");
      $finish;
   end

   initial begin
      error_count     = 0;
      search_count    = 0;
      step_count      = 0;
      not_found_count = 0;
      accepted_count  = 0;
      idle_enable     = 1'b1;
      cols_reg        = 4'd8;
      rows_reg        = 4'd8;
      for (int i = 0; i < gapf_pkg::CELL_COUNT; i++) begin
         walls[i] = 1'b0;
      end
      reset       <= 1'b1;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= '0;
      csr_pwdata  <= '0;
      req_chan.valid     <= 1'b0;
      req_chan.operation <= gapf_pkg::OP_WALL;
      req_chan.cell_x    <= '0;
      req_chan.cell_y    <= '0;
      req_chan.is_wall   <= 1'b0;
      req_chan.start_x   <= '0;
      req_chan.start_y   <= '0;
      req_chan.goal_x    <= '0;
      req_chan.goal_y    <= '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_area_limits();
      test_random_areas();
      idle_enable = 1'b0;
      test_random_maze(20);
      wait_drained();
      repeat (200) @(posedge clock);
      $display("covered %0d requests, %0d searches, %0d path cells, %0d unreachable",
               accepted_count, search_count, step_count, not_found_count);
      if (error_count == 0 && expected_steps.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

// ----- files.f -----
hw/rtl/gapf_pkg.sv
hw/rtl/gapf_req_if.sv
hw/rtl/gapf_rsp_if.sv
hw/rtl/gapf_ram.sv
hw/rtl/gapf_ctrl.sv
hw/rtl/gapf_dp.sv
hw/rtl/grid_astar_path_finder.sv
hw/rtl/gapf_checker.sv
test/grid_astar_path_finder_tb.sv
